### design/evmp_pkg.sv
// evmp_pkg: shared types, constants and the vendor code lookup for the
// display identification block parser; no dependencies
package evmp_pkg;

    localparam int NAME_LEN      = 13;
    localparam int BLOCK_BYTES   = 128;
    localparam int MAKER_COUNT   = 24;
    localparam int QUEUE_DEPTH   = 2;

    localparam int POS_W      = $clog2(BLOCK_BYTES);
    localparam int NAME_IDX_W = $clog2(NAME_LEN);
    localparam int OFF_W      = 5;

    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BLOCK_BYTES - 1);
    localparam logic [POS_W-1:0] HDR_LAST   = POS_W'(7);
    localparam logic [POS_W-1:0] POS_VND_HI = POS_W'(8);
    localparam logic [POS_W-1:0] POS_VND_LO = POS_W'(9);
    localparam logic [POS_W-1:0] DESC_FIRST = POS_W'(8'h36);
    localparam logic [POS_W-1:0] DESC_END   = POS_W'(8'h7E);
    localparam logic [OFF_W-1:0] DESC_LAST_OFF = OFF_W'(8'h12 - 1);
    localparam logic [OFF_W-1:0] OFF_FIRST  = OFF_W'(0);
    localparam logic [OFF_W-1:0] OFF_TAG    = OFF_W'(3);
    localparam logic [OFF_W-1:0] OFF_NAME   = OFF_W'(5);

    localparam logic [7:0] NAME_TAG  = 8'hfc;
    localparam logic [7:0] LINE_FEED = 8'h0a;
    localparam logic [7:0] BYTE_ONES = 8'hff;

    localparam logic [4:0] MAKER_UNKNOWN = 5'(MAKER_COUNT);

    // three ascii letters per entry, first letter in the top byte
    localparam logic [23:0] MAKER_CODES [MAKER_COUNT] = '{
        "AOC", "ACR", "APP", "ASU", "BNQ", "CMN", "DEL", "ENC",
        "FUJ", "GSM", "HWP", "LEN", "LPL", "MSI", "NEC", "PHL",
        "SAM", "SEC", "SGI", "SON", "TOS", "VIZ", "VSC", "YMH"
    };

    // one finished block, handed from the parser to the emitter
    typedef struct packed {
        logic                          hdr_ok;
        logic                          name_found;
        logic [7:0]                    vnd_hi;
        logic [7:0]                    vnd_lo;
        logic [NAME_LEN-1:0][7:0]      name;
    } evmp_summary_t;

    // first matching table entry, or the unknown index
    function automatic logic [4:0] maker_lookup(input logic [4:0] c1,
                                                input logic [4:0] c2,
                                                input logic [4:0] c3);
        logic [4:0] idx;
        idx = MAKER_UNKNOWN;
        for (int k = MAKER_COUNT - 1; k >= 0; k--) begin
            if (MAKER_CODES[k][20:16] == c1 && MAKER_CODES[k][12:8] == c2 &&
                MAKER_CODES[k][4:0] == c3) begin
                idx = 5'(k);
            end
        end
        return idx;
    endfunction

endpackage

### design/edid_vendor_model_parser.sv
// edid_vendor_model_parser: top level, parser front, summary queue and
// result emitter; depends on evmp_pkg, evmp_front, evmp_queue, evmp_back
//
//   channel | dir | tdata                        | tuser                  | tlast
//   s_      | in  | data_byte [7:0]              | start_of_block         | -
//   m_      | out | vendor letters, maker, index,| header_ok, name_found  | last
//           |     | model_char (see port)        |                        |
//
// one byte word accepted per cycle while the summary queue has room
// byte 127 pushes a block summary; the emitter gives 13 words per block
// (one on a bad header), one per cycle while m_tready is high, from a registered output stage
// the queue holds QUEUE_DEPTH summaries; input stalls only when it is full
// aresetn is synchronous, active low, and clears position and queue
module edid_vendor_model_parser
    import evmp_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] start_of_block
    output logic        m_tvalid,
    input  logic        m_tready,
    // [6:0] vendor_char_first, [13:7] vendor_char_second,
    // [20:14] vendor_char_third, [25:21] maker_index, [29:26] char_index,
    // [37:30] model_char, [39:38] zero
    output logic [39:0] m_tdata,
    output logic [1:0]  m_tuser,   // [0] header_ok, [1] name_found
    output logic        m_tlast    // last
);

    logic          push;
    evmp_summary_t push_data;
    logic          q_full;
    logic          pop;
    logic          head_valid;
    evmp_summary_t head;

    // parser front: classifies each byte by position
    evmp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_start  (s_tuser),
        .in_ready  (s_tready),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    // decouples byte intake from the result burst
    evmp_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // emitter: one result word per name character, a single word on a bad header
    evmp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // a bad header gives a single word run
    a_bad_hdr_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata[37:26] == '0)
        else $error("bad header word is not a lone last word");

    // a good header run ends on the final name character
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast == (m_tdata[29:26] == 4'(NAME_LEN - 1)))
        else $error("last flag out of step with char index");

    // characters count up inside a run
    a_char_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast && m_tuser[0] ##1 m_tvalid |->
        m_tdata[29:26] == $past(m_tdata[29:26]) + 4'(1))
        else $error("char index did not advance");
`endif

endmodule

### design/evmp_front.sv
// evmp_front: byte parser, tracks position, header, vendor bytes and name
// descriptor; depends on evmp_pkg
module evmp_front
    import evmp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic [7:0]    in_byte,
    input  logic          in_start,
    output logic          in_ready,
    output logic          push,
    output evmp_summary_t push_data,
    input  logic          q_full
);

    logic [POS_W-1:0]         pos_reg, pos_next, pos_eff;
    logic [OFF_W-1:0]         off_reg, off_next, off_eff;
    logic                     hdr_reg, hdr_next, hdr_eff;
    logic [7:0]               vhi_reg, vhi_next, vhi_eff;
    logic [7:0]               vlo_reg, vlo_next, vlo_eff;
    logic                     blank_reg, blank_next, blank_eff;
    logic                     isname_reg, isname_next, isname_eff;
    logic                     seen_reg, seen_next, seen_eff;
    logic [NAME_LEN-1:0][7:0] name_reg, name_next, name_eff;
    logic                     accept;
    logic                     in_desc;
    logic [OFF_W-1:0]         name_k;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // start mark drops whatever was parsed so far
    assign pos_eff    = in_start ? '0 : pos_reg;
    assign off_eff    = in_start ? '0 : off_reg;
    assign hdr_eff    = in_start ? 1'b1 : hdr_reg;
    assign vhi_eff    = in_start ? '0 : vhi_reg;
    assign vlo_eff    = in_start ? '0 : vlo_reg;
    assign blank_eff  = in_start ? 1'b0 : blank_reg;
    assign isname_eff = in_start ? 1'b0 : isname_reg;
    assign seen_eff   = in_start ? 1'b0 : seen_reg;
    assign name_eff   = in_start ? '0 : name_reg;

    assign in_desc = (pos_eff >= DESC_FIRST) && (pos_eff < DESC_END);
    assign name_k  = off_eff - OFF_NAME;

    always_comb begin
        pos_next    = pos_eff + POS_W'(1);
        off_next    = off_eff;
        hdr_next    = hdr_eff;
        vhi_next    = vhi_eff;
        vlo_next    = vlo_eff;
        blank_next  = blank_eff;
        isname_next = isname_eff;
        seen_next   = seen_eff;
        name_next   = name_eff;
        if (pos_eff <= HDR_LAST) begin
            if (!(in_byte == BYTE_ONES ||
                  ((pos_eff == '0 || pos_eff == HDR_LAST) && in_byte == '0))) begin
                hdr_next = 1'b0;
            end
        end else if (pos_eff == POS_VND_HI) begin
            vhi_next = in_byte;
        end else if (pos_eff == POS_VND_LO) begin
            vlo_next = in_byte;
        end else if (in_desc) begin
            off_next = (off_eff == DESC_LAST_OFF) ? '0 : off_eff + OFF_W'(1);
            if (off_eff == OFF_FIRST) begin
                blank_next  = (in_byte == '0);
                isname_next = 1'b0;
            end else if (off_eff == OFF_TAG) begin
                isname_next = blank_eff && (in_byte == NAME_TAG);
                if (blank_eff && (in_byte == NAME_TAG)) begin
                    seen_next = 1'b1;
                end
            end else if (off_eff >= OFF_NAME && isname_eff) begin
                name_next[name_k[NAME_IDX_W-1:0]] =
                    (in_byte == LINE_FEED) ? '0 : in_byte;
            end
        end
        // end of block: back to reset values
        if (pos_eff == POS_LAST) begin
            pos_next    = '0;
            off_next    = '0;
            hdr_next    = 1'b1;
            vhi_next    = '0;
            vlo_next    = '0;
            blank_next  = 1'b0;
            isname_next = 1'b0;
            seen_next   = 1'b0;
            name_next   = '0;
        end
    end

    assign push                 = accept && (pos_eff == POS_LAST);
    assign push_data.hdr_ok     = hdr_eff;
    assign push_data.name_found = seen_eff;
    assign push_data.vnd_hi     = vhi_eff;
    assign push_data.vnd_lo     = vlo_eff;
    assign push_data.name       = name_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            off_reg    <= '0;
            hdr_reg    <= 1'b1;
            vhi_reg    <= '0;
            vlo_reg    <= '0;
            blank_reg  <= 1'b0;
            isname_reg <= 1'b0;
            seen_reg   <= 1'b0;
            name_reg   <= '0;
        end else if (accept) begin
            pos_reg    <= pos_next;
            off_reg    <= off_next;
            hdr_reg    <= hdr_next;
            vhi_reg    <= vhi_next;
            vlo_reg    <= vlo_next;
            blank_reg  <= blank_next;
            isname_reg <= isname_next;
            seen_reg   <= seen_next;
            name_reg   <= name_next;
        end
    end

endmodule

### design/evmp_queue.sv
// evmp_queue: short queue of block summaries between parser and emitter;
// depends on evmp_pkg
module evmp_queue
    import evmp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  evmp_summary_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output evmp_summary_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

    evmp_summary_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_reg <= (wr_reg == PTR_MAX) ? '0 : wr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == PTR_MAX) ? '0 : rd_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

### design/evmp_back.sv
// evmp_back: emitter, walks one block summary into result words with a
// registered output stage; depends on evmp_pkg
module evmp_back
    import evmp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  evmp_summary_t head,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);

    logic [NAME_IDX_W-1:0] k_reg;
    logic                  ended_reg;
    logic                  valid_reg;
    logic [39:0]           data_reg;
    logic [1:0]            user_reg;
    logic                  last_reg;
    logic                  load;
    logic [4:0]            c1, c2, c3;
    logic [7:0]            raw_char;
    logic                  zero_char;
    logic                  is_last;
    logic [3:0]            cidx;
    logic [7:0]            mchar;

    assign load = head_valid && (!valid_reg || m_tready);

    assign c1 = head.vnd_hi[6:2];
    assign c2 = {head.vnd_hi[1:0], head.vnd_lo[7:5]};
    assign c3 = head.vnd_lo[4:0];

    assign raw_char  = head.name[k_reg];
    assign zero_char = ended_reg || (raw_char == '0);

    always_comb begin
        if (!head.hdr_ok) begin
            is_last = 1'b1;
            cidx    = '0;
            mchar   = '0;
        end else begin
            is_last = (k_reg == NAME_IDX_W'(NAME_LEN - 1));
            cidx    = 4'(k_reg);
            mchar   = zero_char ? '0 : raw_char;
        end
    end

    assign pop = load && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            k_reg     <= '0;
            ended_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                k_reg     <= is_last ? '0 : k_reg + NAME_IDX_W'(1);
                ended_reg <= is_last ? 1'b0 : zero_char;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {2'b00, mchar, cidx, maker_lookup(c1, c2, c3),
                         2'b10, c3, 2'b10, c2, 2'b10, c1};
            user_reg <= {head.hdr_ok && head.name_found, head.hdr_ok};
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule
